[sv/cfc_pkg.sv]
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants for the circular FIFO controller: sizes,
// operation and status codes, and the result record that passes from the
// pointer unit to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned PtrWidth  = $clog2(Depth);
  localparam int unsigned LenWidth  = 5;
  localparam int unsigned FillWidth = 4;
  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;

  localparam logic [LenWidth-1:0] LenReset = LenWidth'(Depth);
  localparam logic [LenWidth-1:0] LenMin   = LenWidth'(2);
  localparam logic [LenWidth-1:0] LenMax   = LenWidth'(Depth);

  localparam logic [PaddrWidth-3:0] RegFifoLength = '0;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_PEEK  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    status_e                status;
    logic                   head_valid;
    logic                   prev_valid;
    logic                   prev_fwd;
    logic [DataWidth-1:0]   fwd_data;
    logic [FillWidth-1:0]   fill;
    logic                   empty;
  } rsp_t;

endpackage

`default_nettype wire

[sv/cfc_ram.sv]
// ----------------------------------------------------------------------------
// cfc_ram
// Generic synchronous RAM with one write port and two read ports. Read data
// is registered and shows the contents before a write in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

[sv/cfc_ptr.sv]
// ----------------------------------------------------------------------------
// cfc_ptr
// Pointer unit: holds the read and write pointers, decodes each operation,
// drives the slot RAM addresses and registers the result record.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_ptr (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [1:0]                     kind_i,
  input  wire logic [cfc_pkg::DataWidth-1:0]  push_data_i,
  input  wire logic [cfc_pkg::LenWidth-1:0]   length_i,
  output logic                                we_o,
  output logic      [cfc_pkg::PtrWidth-1:0]   waddr_o,
  output logic      [cfc_pkg::DataWidth-1:0]  wdata_o,
  output logic      [cfc_pkg::PtrWidth-1:0]   raddr_head_o,
  output logic      [cfc_pkg::PtrWidth-1:0]   raddr_prev_o,
  output logic                                done_o,
  output cfc_pkg::rsp_t                       rsp_o
);

  import cfc_pkg::*;

  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic                done_q;
  rsp_t                rsp_q, rsp_d;

  logic [LenWidth-1:0] ring_len;
  logic [LenWidth-1:0] wr_inc_w, rd_inc_w;
  logic [PtrWidth-1:0] wr_next, rd_next, prev_ptr;
  logic [LenWidth-1:0] fill_sum;
  logic                was_empty, now_empty, push_ok;
  kind_e               kind;
  status_e             status;

  always_comb begin
    if (length_i < LenMin) begin
      ring_len = LenMin;
    end else if (length_i > LenMax) begin
      ring_len = LenMax;
    end else begin
      ring_len = length_i;
    end
  end

  always_comb begin
    wr_inc_w = LenWidth'(wr_ptr_q) + LenWidth'(1);
    rd_inc_w = LenWidth'(rd_ptr_q) + LenWidth'(1);
    wr_next  = (wr_inc_w >= ring_len) ? '0 : wr_inc_w[PtrWidth-1:0];
    rd_next  = (rd_inc_w >= ring_len) ? '0 : rd_inc_w[PtrWidth-1:0];
  end

  always_comb begin
    kind      = kind_e'(kind_i);
    was_empty = (rd_ptr_q == wr_ptr_q);
    push_ok   = 1'b0;
    status    = STATUS_OK;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    case (kind)
      KIND_PUSH: begin
        if (wr_next == rd_ptr_q) begin
          status = STATUS_FULL;
        end else begin
          push_ok  = 1'b1;
          wr_ptr_d = wr_next;
        end
      end
      KIND_POP: begin
        if (was_empty) begin
          status = STATUS_EMPTY;
        end else begin
          rd_ptr_d = rd_next;
        end
      end
      KIND_CLEAR: begin
        rd_ptr_d = wr_ptr_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    now_empty = (rd_ptr_d == wr_ptr_d);
    if (rd_ptr_d == '0) begin
      prev_ptr = PtrWidth'(ring_len - LenWidth'(1));
    end else begin
      prev_ptr = rd_ptr_d - PtrWidth'(1);
    end
    if (wr_ptr_d >= rd_ptr_d) begin
      fill_sum = LenWidth'(wr_ptr_d) - LenWidth'(rd_ptr_d);
    end else begin
      fill_sum = LenWidth'(wr_ptr_d) + ring_len - LenWidth'(rd_ptr_d);
    end
  end

  always_comb begin
    rsp_d.status     = status;
    rsp_d.head_valid = !was_empty;
    rsp_d.prev_valid = (prev_ptr != wr_ptr_d) && !now_empty;
    rsp_d.prev_fwd   = push_ok && (prev_ptr == wr_ptr_q);
    rsp_d.fwd_data   = push_data_i;
    rsp_d.fill       = fill_sum[FillWidth-1:0];
    rsp_d.empty      = now_empty;
  end

  assign we_o         = accept_i && push_ok;
  assign waddr_o      = wr_ptr_q;
  assign wdata_o      = push_data_i;
  assign raddr_head_o = rd_ptr_q;
  assign raddr_prev_o = prev_ptr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= accept_i;
      if (accept_i) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

[sv/circular_fifo_controller.sv]
// ----------------------------------------------------------------------------
// circular_fifo_controller
// Circular FIFO over a ring of configurable length with one slot kept free.
// Operations are push, pop, clear and peek; each one returns a status, the
// head word, the word behind the head, the fill count and an empty flag.
//
//   Channel   Handshake                      Payload
//   -------   ----------------------------   ---------------------------------
//   command   start, busy                    kind_i, push_data_i
//   result    done_o (one-cycle strobe)      status_o, head_data_o,
//                                            previous_data_o, previous_valid_o,
//                                            fill_count_o, is_empty_o
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One operation is accepted every cycle; busy is never raised. The result of
// a transaction appears in the cycle after acceptance, through the registered
// read of the slot RAM. A push writes the RAM in the accepting cycle, so the
// next transaction reads the new word; a write into the slot behind the head
// is forwarded. Reset clears both pointers and sets the length to sixteen;
// the slot RAM is not cleared. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_controller (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       kind_i,
  input  wire logic [cfc_pkg::DataWidth-1:0]    push_data_i,
  output logic                                  done_o,
  output logic      [1:0]                       status_o,
  output logic      [cfc_pkg::DataWidth-1:0]    head_data_o,
  output logic      [cfc_pkg::DataWidth-1:0]    previous_data_o,
  output logic                                  previous_valid_o,
  output logic      [cfc_pkg::FillWidth-1:0]    fill_count_o,
  output logic                                  is_empty_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [cfc_pkg::PaddrWidth-1:0]   paddr,
  input  wire logic [cfc_pkg::PdataWidth-1:0]   pwdata,
  output logic      [cfc_pkg::PdataWidth-1:0]   prdata,
  output logic                                  pready
);

  import cfc_pkg::*;

  logic [LenWidth-1:0]  length_q;
  logic                 accept;
  logic                 cfg_write;
  logic                 we;
  logic [PtrWidth-1:0]  waddr, raddr_head, raddr_prev;
  logic [DataWidth-1:0] wdata, rdata_head, rdata_prev;
  rsp_t                 rsp;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= LenReset;
    end else if (cfg_write && (paddr[PaddrWidth-1:2] == RegFifoLength)) begin
      length_q <= pwdata[LenWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PaddrWidth-1:2] == RegFifoLength) begin
      prdata = PdataWidth'(length_q);
    end
  end

  cfc_ptr u_ptr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .push_data_i  (push_data_i),
    .length_i     (length_q),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_head_o (raddr_head),
    .raddr_prev_o (raddr_prev),
    .done_o       (done_o),
    .rsp_o        (rsp)
  );

  cfc_ram #(
    .Width (DataWidth),
    .Depth (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_head),
    .raddr_b_i (raddr_prev),
    .rdata_a_o (rdata_head),
    .rdata_b_o (rdata_prev)
  );

  always_comb begin
    status_o         = rsp.status;
    head_data_o      = rsp.head_valid ? rdata_head : '0;
    previous_valid_o = rsp.prev_valid;
    if (!rsp.prev_valid) begin
      previous_data_o = '0;
    end else if (rsp.prev_fwd) begin
      previous_data_o = rsp.fwd_data;
    end else begin
      previous_data_o = rdata_prev;
    end
    fill_count_o = rsp.fill;
    is_empty_o   = rsp.empty;
  end

endmodule

`default_nettype wire

[dv/tb_circular_fifo_controller.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_fifo_controller
// Self-checking bench for the circular FIFO controller. Operations go in one
// per transaction through the start/busy handshake, and the ring length is
// changed through the APB-style port between phases. A scoreboard keeps its
// own copy of the ring and its pointers, predicts each result and compares
// every strobed result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_circular_fifo_controller;
  import cfc_pkg::*;

  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned PhaseCount = 12;
  localparam int unsigned PhaseItems = 36;
  localparam logic [PaddrWidth-1:0] AddrFifoLength = {RegFifoLength, 2'b00};

  typedef struct packed {
    status_e                status;
    logic [DataWidth-1:0]   head;
    logic [DataWidth-1:0]   prev;
    logic                   prev_valid;
    logic [FillWidth-1:0]   fill;
    logic                   empty;
  } fifo_result_t;

  class fifo_scoreboard;
    logic [DataWidth-1:0] slot_word [Depth];
    bit                   slot_written [Depth];
    int unsigned          rd_ptr;
    int unsigned          wr_ptr;
    logic [LenWidth-1:0]  length_reg;
    fifo_result_t         expected_q [$];
    int unsigned          mismatches;
    int unsigned          results_seen;
    int unsigned          full_pushes;
    int unsigned          empty_pops;
    int unsigned          clears;

    function new();
      rd_ptr = 0;
      wr_ptr = 0;
      length_reg = LenReset;
      foreach (slot_written[i]) begin
        slot_written[i] = 1'b0;
        slot_word[i] = '0;
      end
    endfunction

    function int unsigned ring_len();
      int unsigned n;
      n = length_reg;
      if (n < LenMin) n = LenMin;
      if (n > LenMax) n = LenMax;
      return n;
    endfunction

    function int unsigned advance(int unsigned p, int unsigned n);
      return (p + 1 >= n) ? 0 : p + 1;
    endfunction

    // Works out the result of one operation. The return value flags any read
    // of a slot that has never been written, now or by the next operation.
    function bit evaluate(kind_e op, logic [DataWidth-1:0] word, bit commit,
                          output fifo_result_t res);
      int unsigned n;
      int unsigned rd;
      int unsigned wr;
      int unsigned wr_slot;
      int unsigned behind;
      bit          was_empty;
      bit          stored;
      bit          hazard;
      n = ring_len();
      rd = rd_ptr;
      wr = wr_ptr;
      wr_slot = 0;
      stored = 1'b0;
      res = '0;
      res.status = STATUS_OK;
      was_empty = (rd == wr);
      hazard = !was_empty && !slot_written[rd];
      res.head = was_empty ? '0 : slot_word[rd];
      case (op)
        KIND_PUSH: begin
          if (advance(wr, n) == rd) begin
            res.status = STATUS_FULL;
          end else begin
            stored = 1'b1;
            wr_slot = wr;
            wr = advance(wr, n);
          end
        end
        KIND_POP: begin
          if (was_empty) res.status = STATUS_EMPTY;
          else rd = advance(rd, n);
        end
        KIND_CLEAR: begin
          rd = wr;
        end
        default: begin
        end
      endcase
      res.empty = (rd == wr);
      behind = (rd == 0) ? n - 1 : rd - 1;
      res.prev_valid = (behind != wr) && !res.empty;
      if (res.prev_valid) begin
        if (stored && behind == wr_slot) begin
          res.prev = word;
        end else begin
          res.prev = slot_word[behind];
          hazard |= !slot_written[behind];
        end
      end
      hazard |= !res.empty && !(slot_written[rd] || (stored && rd == wr_slot));
      res.fill = FillWidth'((wr >= rd) ? wr - rd : wr + n - rd);
      if (commit) begin
        if (stored) begin
          slot_word[wr_slot] = word;
          slot_written[wr_slot] = 1'b1;
        end
        rd_ptr = rd;
        wr_ptr = wr;
      end
      return hazard;
    endfunction

    function bit is_safe(kind_e op);
      fifo_result_t unused;
      return !evaluate(op, '0, 1'b0, unused);
    endfunction

    function void note_command(kind_e op, logic [DataWidth-1:0] word);
      fifo_result_t res;
      void'(evaluate(op, word, 1'b1, res));
      expected_q.push_back(res);
      if (res.status == STATUS_FULL) full_pushes++;
      if (res.status == STATUS_EMPTY) empty_pops++;
      if (op == KIND_CLEAR) clears++;
    endfunction

    function void report(string what, fifo_result_t exp, fifo_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s", $time, what);
        $display("  expected status %0d head %h prev %h valid %b fill %0d empty %b",
                 exp.status, exp.head, exp.prev, exp.prev_valid, exp.fill, exp.empty);
        $display("  actual   status %0d head %h prev %h valid %b fill %0d empty %b",
                 got.status, got.head, got.prev, got.prev_valid, got.fill, got.empty);
      end
    endfunction

    function void check_result(fifo_result_t got);
      fifo_result_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with no transaction outstanding", '0, got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status || got.head !== exp.head ||
          got.prev !== exp.prev || got.prev_valid !== exp.prev_valid ||
          got.fill !== exp.fill || got.empty !== exp.empty) begin
        report("result mismatch", exp, got);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [1:0]            kind;
  logic [DataWidth-1:0]  push_data;
  logic                  done;
  logic [1:0]            status;
  logic [DataWidth-1:0]  head_data;
  logic [DataWidth-1:0]  previous_data;
  logic                  previous_valid;
  logic [FillWidth-1:0]  fill_count;
  logic                  is_empty;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [PdataWidth-1:0] pwdata;
  logic [PdataWidth-1:0] prdata;
  logic                  pready;

  fifo_scoreboard sb;
  int unsigned    idle_cycles;
  int unsigned    lengths_used;

  circular_fifo_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind),
    .push_data_i      (push_data),
    .done_o           (done),
    .status_o         (status),
    .head_data_o      (head_data),
    .previous_data_o  (previous_data),
    .previous_valid_o (previous_valid),
    .fill_count_o     (fill_count),
    .is_empty_o       (is_empty),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    fifo_result_t got;
    if (rst_ni) begin
      if (start && !busy) sb.note_command(kind_e'(kind), push_data);
      if (done) begin
        got.status = status_e'(status);
        got.head = head_data;
        got.prev = previous_data;
        got.prev_valid = previous_valid;
        got.fill = fill_count;
        got.empty = is_empty;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Timed out after %0d cycles without a transaction.", IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_command(kind_e op, logic [DataWidth-1:0] word);
    @(negedge clk_i);
    if (!sb.is_safe(op)) op = KIND_CLEAR;
    start = 1'b1;
    kind = op;
    push_data = word;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause_sender(int unsigned cycles);
    @(negedge clk_i);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_length(logic [LenWidth-1:0] len);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = AddrFifoLength;
    pwdata = PdataWidth'(len);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.length_reg = len;
    lengths_used++;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic run_random(int unsigned count, int unsigned push_pct, bit gaps,
                            bit hold);
    int unsigned roll;
    kind_e       op;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) op = KIND_PUSH;
      else if (roll < 88) op = KIND_POP;
      else if (roll < 95) op = KIND_PEEK;
      else op = KIND_CLEAR;
      send_command(op, $urandom());
      if (gaps && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 3));
      if (hold && i == count / 2) begin
        pause_sender(1);
        wait_drained();
      end
    end
  endtask

  initial begin
    logic [LenWidth-1:0] phase_len [PhaseCount];
    phase_len = '{5'd5, 5'd16, 5'd0, 5'd9, 5'd31, 5'd3, 5'd1, 5'd12, 5'd17, 5'd2,
                  5'd16, 5'd7};
    phase_len[PhaseCount-1] = LenWidth'($urandom_range(0, 31));
    rst_ni = 1'b0;
    start = 1'b0;
    kind = KIND_PEEK;
    push_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    lengths_used = 0;
    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The shortest ring first, so that every slot is written before the
    // slot behind the head can be read.
    write_length(LenMin);
    send_command(KIND_PUSH, 32'h0000_0000);
    send_command(KIND_PEEK, 32'h1234_5678);
    send_command(KIND_POP, 32'hFFFF_FFFF);
    send_command(KIND_POP, 32'h0000_0000);
    send_command(KIND_PUSH, 32'hFFFF_FFFF);
    send_command(KIND_PUSH, 32'h5555_5555);
    send_command(KIND_CLEAR, 32'hAAAA_AAAA);
    send_command(KIND_PUSH, 32'h8000_0001);
    send_command(KIND_POP, 32'h0000_0000);
    pause_sender(1);
    wait_drained();
    write_length(LenMax);
    for (int unsigned i = 0; i < Depth - 1; i++) begin
      case (i % 4)
        0: send_command(KIND_PUSH, 32'hAAAA_AAAA);
        1: send_command(KIND_PUSH, 32'h5555_5555);
        2: send_command(KIND_PUSH, 32'hFFFF_FFFF);
        default: send_command(KIND_PUSH, $urandom());
      endcase
    end
    send_command(KIND_PUSH, 32'hDEAD_0000);
    send_command(KIND_PEEK, 32'h0000_0000);
    send_command(KIND_POP, 32'h0000_0000);
    send_command(KIND_CLEAR, 32'h0000_0000);

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      pause_sender(1);
      wait_drained();
      write_length(phase_len[p]);
      run_random(PhaseItems, (p % 2 == 0) ? 62 : 35, p < PhaseCount - 2, p == 1);
    end
    pause_sender(1);
    wait_drained();

    $display("Checked %0d results over %0d ring-length settings, out-of-range ones included.",
             sb.results_seen, lengths_used);
    $display("Saw %0d pushes refused as full, %0d pops on an empty ring and %0d clears.",
             sb.full_pushes, sb.empty_pops, sb.clears);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/cfc_pkg.sv
sv/cfc_ram.sv
sv/cfc_ptr.sv
sv/circular_fifo_controller.sv
dv/tb_circular_fifo_controller.sv
